// ===== sv/sbsm_pkg.sv =====
// Shared types, codes and constants of the serial bank switch mapper.
package sbsm_pkg;

  localparam int unsigned PrgRamBytes = 8192;
  localparam int unsigned PrgRamAw    = $clog2(PrgRamBytes);

  localparam logic [4:0] ShiftEmpty   = 5'h10;
  localparam logic [4:0] ControlReset = 5'h0C;
  localparam logic [4:0] PrgModeFix   = 5'h0C;

  typedef enum logic [2:0] {
    CmdSerialWrite = 3'd0,
    CmdPrgRom      = 3'd1,
    CmdPrgRam      = 3'd2,
    CmdPattern     = 3'd3,
    CmdReset       = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    CfgPrgSizeLog2   = 2'd0,
    CfgChrSizeLog2   = 2'd1,
    CfgFixed32kBoard = 2'd2,
    CfgRamEnByBank   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SelControl = 2'd0,
    SelChrLow  = 2'd1,
    SelChrHigh = 2'd2,
    SelPrg     = 2'd3
  } reg_sel_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] bus_addr;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [18:0] mem_index;
    logic        available;
    logic [1:0]  mirror_mode;
  } out_item_t;

  typedef struct packed {
    logic [4:0] prg_size_log2;
    logic [4:0] chr_size_log2;
    logic       fixed_32k_board;
    logic       ram_enable_by_bank_bit;
  } cfg_t;

  typedef struct packed {
    logic [4:0] control;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [4:0] prg;
  } bank_state_t;

endpackage

// ===== sv/sbsm_cfg.sv =====
// Configuration registers of the serial bank switch mapper.
module sbsm_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [4:0]         cfg_wdata_i,
  output sbsm_pkg::cfg_t     cfg_o
);

  sbsm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sbsm_pkg::CfgPrgSizeLog2:   cfg_d.prg_size_log2 = cfg_wdata_i;
        sbsm_pkg::CfgChrSizeLog2:   cfg_d.chr_size_log2 = cfg_wdata_i;
        sbsm_pkg::CfgFixed32kBoard: cfg_d.fixed_32k_board = cfg_wdata_i[0];
        sbsm_pkg::CfgRamEnByBank:   cfg_d.ram_enable_by_bank_bit = cfg_wdata_i[0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prg_size_log2          <= 5'd18;
      cfg_q.chr_size_log2          <= 5'd13;
      cfg_q.fixed_32k_board        <= 1'b0;
      cfg_q.ram_enable_by_bank_bit <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/sbsm_bank_regs.sv =====
// Serial shifter and bank registers, updated once per processed item.
module sbsm_bank_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  sbsm_pkg::in_item_t    item_i,
  input  sbsm_pkg::cfg_t        cfg_i,
  output sbsm_pkg::bank_state_t bank_o,
  output logic [1:0]            mirror_next_o
);

  sbsm_pkg::bank_state_t bank_q, bank_d;
  logic [4:0] shift_q, shift_d;
  logic [4:0] shifted;
  logic [1:0] sel;

  always_comb begin
    bank_d  = bank_q;
    shift_d = shift_q;
    shifted = {item_i.write_data[0], shift_q[4:1]};
    sel     = item_i.bus_addr[15] ? item_i.bus_addr[14:13] : sbsm_pkg::SelControl;
    unique case (item_i.cmd)
      sbsm_pkg::CmdSerialWrite: begin
        if (item_i.write_data[7]) begin
          shift_d        = sbsm_pkg::ShiftEmpty;
          bank_d.control = bank_q.control | sbsm_pkg::PrgModeFix;
        end else if (shift_q[0]) begin
          shift_d = sbsm_pkg::ShiftEmpty;
          unique case (sel)
            sbsm_pkg::SelControl: bank_d.control  = shifted;
            sbsm_pkg::SelChrLow:  bank_d.chr_low  = shifted;
            sbsm_pkg::SelChrHigh: bank_d.chr_high = shifted;
            sbsm_pkg::SelPrg:     bank_d.prg      = shifted;
            default:              bank_d          = bank_q;
          endcase
        end else begin
          shift_d = shifted;
        end
      end
      sbsm_pkg::CmdReset: begin
        shift_d         = sbsm_pkg::ShiftEmpty;
        bank_d.control  = sbsm_pkg::ControlReset;
        bank_d.chr_low  = 5'd0;
        bank_d.chr_high = 5'd0;
        bank_d.prg      = cfg_i.ram_enable_by_bank_bit ? {1'b0, bank_q.prg[3:0]} : 5'd0;
      end
      default: begin
        bank_d  = bank_q;
        shift_d = shift_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q         <= sbsm_pkg::ShiftEmpty;
      bank_q.control  <= sbsm_pkg::ControlReset;
      bank_q.chr_low  <= 5'd0;
      bank_q.chr_high <= 5'd0;
      bank_q.prg      <= 5'd0;
    end else if (step_i) begin
      shift_q <= shift_d;
      bank_q  <= bank_d;
    end
  end

  assign bank_o        = bank_q;
  assign mirror_next_o = bank_d.control[1:0];

  a_shift_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_q != 5'd0)
    else $error("serial shifter lost its marker bit");

  a_write_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.cmd == sbsm_pkg::CmdSerialWrite && item_i.write_data[7]
    |=> shift_q == sbsm_pkg::ShiftEmpty && bank_q.control[3:2] == 2'b11)
    else $error("serial reset did not clear the shifter and fix PRG mode");

endmodule

// ===== sv/sbsm_xlate.sv =====
// Address translation for PRG ROM, PRG RAM and pattern-table accesses.
module sbsm_xlate (
  input  sbsm_pkg::in_item_t    item_i,
  input  sbsm_pkg::cfg_t        cfg_i,
  input  sbsm_pkg::bank_state_t bank_i,
  input  logic [1:0]            mirror_i,
  output sbsm_pkg::out_item_t   res_o
);

  logic [4:0]  prg_lg, chr_lg;
  logic [18:0] prg_mask;
  logic [16:0] chr_mask;
  logic [18:0] prg_idx;
  logic [16:0] chr_idx;
  logic [4:0]  bank16;
  logic [15:0] ram_off;
  logic [1:0]  prg_mode;
  logic        upper;

  always_comb begin
    prg_lg = (cfg_i.prg_size_log2 < 5'd14) ? 5'd14 :
             (cfg_i.prg_size_log2 > 5'd19) ? 5'd19 : cfg_i.prg_size_log2;
    chr_lg = (cfg_i.chr_size_log2 < 5'd12) ? 5'd12 :
             (cfg_i.chr_size_log2 > 5'd17) ? 5'd17 : cfg_i.chr_size_log2;
    prg_mask = 19'((20'd1 << prg_lg) - 20'd1);
    chr_mask = 17'((18'd1 << chr_lg) - 18'd1);
    prg_mode = bank_i.control[3:2];
    upper    = item_i.bus_addr[14];

    if (upper == prg_mode[0]) begin
      bank16 = upper ? 5'((6'd1 << (prg_lg - 5'd14)) - 6'd1) : 5'd0;
    end else begin
      bank16 = {1'b0, bank_i.prg[3:0]};
    end

    if (!prg_mode[1]) begin
      prg_idx = {1'b0, bank_i.prg[3:1], item_i.bus_addr[14:0]};
    end else if (cfg_i.fixed_32k_board) begin
      prg_idx = {4'd0, item_i.bus_addr[14:0]};
    end else begin
      prg_idx = {bank16, item_i.bus_addr[13:0]};
    end
    prg_idx = prg_idx & prg_mask;

    if (bank_i.control[4]) begin
      chr_idx = item_i.bus_addr[12] ? {bank_i.chr_high, item_i.bus_addr[11:0]}
                                    : {bank_i.chr_low, item_i.bus_addr[11:0]};
    end else begin
      chr_idx = {bank_i.chr_low[4:1], item_i.bus_addr[12:0]};
    end
    chr_idx = chr_idx & chr_mask;

    ram_off = item_i.bus_addr - 16'h6000;

    res_o.mem_index   = 19'd0;
    res_o.available   = 1'b1;
    res_o.mirror_mode = mirror_i;
    unique case (item_i.cmd)
      sbsm_pkg::CmdPrgRom:  res_o.mem_index = prg_idx;
      sbsm_pkg::CmdPrgRam: begin
        if (cfg_i.ram_enable_by_bank_bit && bank_i.prg[4]) begin
          res_o.available = 1'b0;
        end else begin
          res_o.mem_index = 19'(ram_off[sbsm_pkg::PrgRamAw-1:0]);
        end
      end
      sbsm_pkg::CmdPattern: res_o.mem_index = {2'b00, chr_idx};
      default:              res_o.mem_index = 19'd0;
    endcase
  end

endmodule

// ===== sv/serial_bank_switch_mapper_unit.sv =====
// Top level of the serial bank switch mapper: input register, state, result register.
// Each item is one bus access and gives one result item, which goes from the input
// register to the result register and then to the output; one item is taken every
// cycle while the output is not stalled. The input register feeds the serial shifter,
// the bank registers and the address translation, and the result register holds the
// answer, so one further item can be taken while a result waits, after which the input
// stalls until the result is taken. The user writes the configuration registers through
// the write port only while no item is in flight; the block itself does not enforce it.
module serial_bank_switch_mapper_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [4:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sbsm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sbsm_pkg::out_item_t out_item_o
);

  sbsm_pkg::cfg_t        cfg;
  sbsm_pkg::bank_state_t bank;
  sbsm_pkg::in_item_t    item_q;
  sbsm_pkg::out_item_t   res, res_q;
  logic                  in_valid_q, out_valid_q;
  logic                  advance;
  logic [1:0]            mirror_next;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  sbsm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  sbsm_bank_regs u_bank_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (item_q),
    .cfg_i        (cfg),
    .bank_o       (bank),
    .mirror_next_o(mirror_next)
  );

  sbsm_xlate u_xlate (
    .item_i  (item_q),
    .cfg_i   (cfg),
    .bank_i  (bank),
    .mirror_i(mirror_next),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> in_valid_q)
    else $error("accepted item did not reach the input register");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item did not reach the result register");

  a_unavail_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !res.available |-> item_q.cmd == sbsm_pkg::CmdPrgRam
      && res.mem_index == 19'd0)
    else $error("unavailable result outside a PRG RAM access");

  a_no_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (item_q.cmd == sbsm_pkg::CmdSerialWrite || item_q.cmd == sbsm_pkg::CmdReset)
    |-> res.mem_index == 19'd0 && res.available)
    else $error("write or reset item produced a memory index");

endmodule

// ===== test/sbsm_bank_map_checker.sv =====
// Checker for the serial bank switch mapper: predicts each result item and compares it.
module sbsm_bank_map_checker
  import sbsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  output int unsigned pending_o,
  output int unsigned mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        cfg_q;
  bank_state_t banks;
  logic [4:0]  shift_q;
  out_item_t   expected_maps[$];
  out_item_t   got_map;
  out_item_t   want_map;
  out_item_t   new_map;

  function automatic int unsigned clamp_log2(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic map_access(input in_item_t acc, output out_item_t res);
    int unsigned lg;
    int unsigned idx;
    int unsigned bank;
    logic [1:0]  mode;
    logic        upper;
    logic        last;
    logic [15:0] ram_off;
    idx = 0;
    res.available = 1'b1;
    case (acc.cmd)
      CmdSerialWrite: begin
        if (acc.write_data[7]) begin
          shift_q = ShiftEmpty;
          banks.control = banks.control | PrgModeFix;
        end else begin
          last = shift_q[0];
          shift_q = {acc.write_data[0], shift_q[4:1]};
          if (last) begin
            if (!acc.bus_addr[15]) begin
              banks.control = shift_q;
            end else begin
              case (reg_sel_e'(acc.bus_addr[14:13]))
                SelControl: banks.control = shift_q;
                SelChrLow:  banks.chr_low = shift_q;
                SelChrHigh: banks.chr_high = shift_q;
                default:    banks.prg = shift_q;
              endcase
            end
            shift_q = ShiftEmpty;
          end
        end
      end
      CmdPrgRom: begin
        lg = clamp_log2(cfg_q.prg_size_log2, 14, 19);
        mode = banks.control[3:2];
        if (!mode[1]) begin
          idx = banks.prg[3:1] * 32768 + acc.bus_addr[14:0];
        end else if (cfg_q.fixed_32k_board) begin
          idx = acc.bus_addr[14:0];
        end else begin
          upper = acc.bus_addr[14];
          if (upper == mode[0]) begin
            bank = upper ? (32'd1 << (lg - 14)) - 1 : 0;
          end else begin
            bank = banks.prg[3:0];
          end
          idx = bank * 16384 + acc.bus_addr[13:0];
        end
        idx = idx & ((32'd1 << lg) - 1);
      end
      CmdPrgRam: begin
        if (cfg_q.ram_enable_by_bank_bit && banks.prg[4]) begin
          res.available = 1'b0;
        end else begin
          ram_off = acc.bus_addr - 16'h6000;
          idx = ram_off % PrgRamBytes;
        end
      end
      CmdPattern: begin
        lg = clamp_log2(cfg_q.chr_size_log2, 12, 17);
        if (banks.control[4]) begin
          bank = acc.bus_addr[12] ? banks.chr_high : banks.chr_low;
          idx = bank * 4096 + acc.bus_addr[11:0];
        end else begin
          idx = banks.chr_low[4:1] * 8192 + acc.bus_addr[12:0];
        end
        idx = idx & ((32'd1 << lg) - 1);
      end
      CmdReset: begin
        shift_q = ShiftEmpty;
        banks.control = ControlReset;
        banks.chr_low = '0;
        banks.chr_high = '0;
        if (cfg_q.ram_enable_by_bank_bit) begin
          banks.prg[4] = 1'b0;
        end else begin
          banks.prg = '0;
        end
      end
      default: begin
      end
    endcase
    res.mem_index = 19'(idx);
    res.mirror_mode = banks.control[1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prg_size_log2 = 5'd18;
      cfg_q.chr_size_log2 = 5'd13;
      cfg_q.fixed_32k_board = 1'b0;
      cfg_q.ram_enable_by_bank_bit = 1'b1;
      banks = '0;
      banks.control = ControlReset;
      shift_q = ShiftEmpty;
      expected_maps.delete();
      pending_o = 0;
      mismatch_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_maps.size() == 0) begin
          $error("result item with no access outstanding");
          mismatch_count_o++;
        end else begin
          want_map = expected_maps.pop_front();
          got_map = out_item_i;
          if (got_map.mem_index !== want_map.mem_index) begin
            $error("mem_index: expected %0d, got %0d", want_map.mem_index, got_map.mem_index);
            mismatch_count_o++;
          end
          if (got_map.available !== want_map.available) begin
            $error("available: expected %0d, got %0d", want_map.available, got_map.available);
            mismatch_count_o++;
          end
          if (got_map.mirror_mode !== want_map.mirror_mode) begin
            $error("mirror_mode: expected %0d, got %0d", want_map.mirror_mode,
                   got_map.mirror_mode);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        map_access(in_item_i, new_map);
        expected_maps.push_back(new_map);
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgPrgSizeLog2:   cfg_q.prg_size_log2 = cfg_wdata_i;
          CfgChrSizeLog2:   cfg_q.chr_size_log2 = cfg_wdata_i;
          CfgFixed32kBoard: cfg_q.fixed_32k_board = cfg_wdata_i[0];
          default:          cfg_q.ram_enable_by_bank_bit = cfg_wdata_i[0];
        endcase
      end
      pending_o = expected_maps.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the serial bank switch mapper: clock, reset, stimulus and verdict.
module tb_top
  import sbsm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 20000;
  localparam logic [2:0]  CmdUnusedLow  = 3'd5;
  localparam logic [2:0]  CmdUnusedHigh = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [4:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  int unsigned pending;
  int unsigned mismatches;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  serial_bank_switch_mapper_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  sbsm_bank_map_checker checker_inst (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_item_i       (out_item),
    .pending_o        (pending),
    .mismatch_count_o (mismatches)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue_access(input logic [2:0] cmd, input logic [15:0] addr,
                              input logic [7:0] data);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{cmd: cmd, bus_addr: addr, write_data: data};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_reg(input logic [15:0] addr, input logic [4:0] value);
    logic [7:0]  data;
    logic [15:0] a;
    for (int b = 0; b < 5; b++) begin
      data = 8'($urandom);
      data[7] = 1'b0;
      data[0] = value[b];
      a = (b == 4) ? addr : 16'($urandom);
      issue_access(CmdSerialWrite, a, data);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [4:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input bit set_cfg, input logic [4:0] prg_lg,
                           input logic [4:0] chr_lg, input bit fix32, input bit ram_by_bank,
                           input int unsigned send_pct, input int unsigned stall_pct,
                           input int unsigned hold, input bit pause_mid,
                           input int unsigned count);
    int unsigned issued;
    int unsigned pick;
    bit          paused;
    logic [15:0] addr;
    logic [2:0]  cmd;
    drain_results();
    if (set_cfg) begin
      write_reg(CfgPrgSizeLog2, prg_lg);
      write_reg(CfgChrSizeLog2, chr_lg);
      write_reg(CfgFixed32kBoard, (5'($urandom) & 5'h1E) | 5'(fix32));
      write_reg(CfgRamEnByBank, (5'($urandom) & 5'h1E) | 5'(ram_by_bank));
    end
    sender_idle_pct = send_pct;
    receiver_stall_pct = stall_pct;
    if (hold != 0) begin
      @(posedge clk);
      hold_request = hold;
    end
    issued = 0;
    paused = 1'b0;
    while (issued < count) begin
      if (pause_mid && !paused && issued >= count / 2) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      addr = 16'($urandom);
      if (pick < 30) begin
        if ($urandom_range(0, 4) != 0) addr[15] = 1'b1;
        load_reg(addr, 5'($urandom));
        issued += 5;
      end else if (pick < 38) begin
        issue_access(CmdSerialWrite, addr, 8'($urandom));
        issued++;
      end else if (pick < 92) begin
        cmd = 3'($urandom_range(int'(CmdPrgRom), int'(CmdPattern)));
        if (cmd == CmdPrgRam && $urandom_range(0, 9) < 7) begin
          addr = 16'h6000 + 16'($urandom_range(0, 16'h1FFF));
        end else if (cmd == CmdPattern && $urandom_range(0, 9) < 7) begin
          addr[15:13] = '0;
        end
        issue_access(cmd, addr, 8'($urandom));
        issued++;
      end else if (pick < 96) begin
        issue_access(CmdReset, addr, 8'($urandom));
        issued++;
      end else begin
        issue_access(3'($urandom_range(int'(CmdUnusedLow), int'(CmdUnusedHigh))), addr,
                     8'($urandom));
        issued++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    issue_access(CmdPrgRom, 16'hFFFF, 8'hFF);
    issue_access(CmdPrgRom, 16'h4000, 8'h00);
    issue_access(CmdPrgRam, 16'h6000, 8'h00);
    issue_access(CmdPrgRam, 16'h7FFF, 8'hFF);
    issue_access(CmdPrgRam, 16'h0000, 8'h00);
    issue_access(CmdPattern, 16'h1FFF, 8'h00);
    issue_access(CmdPattern, 16'hFFFF, 8'hFF);
    issue_access(CmdUnusedLow, 16'hFFFF, 8'hFF);
    issue_access(CmdUnusedHigh, 16'h0000, 8'h7F);
    issue_access(CmdSerialWrite, 16'h8000, 8'h80);
    load_reg(16'hE000, 5'h1F);
    issue_access(CmdPrgRam, 16'h6000, 8'h00);
    issue_access(CmdPrgRom, 16'hC000, 8'h00);
    issue_access(CmdReset, 16'hFFFF, 8'hFF);
    issue_access(CmdPrgRam, 16'h6000, 8'h00);
    load_reg(16'h0000, 5'h1F);
    issue_access(CmdPattern, 16'h1000, 8'h00);

    run_phase(1'b0, 5'd18, 5'd13, 1'b0, 1'b1, 0, 0, 0, 1'b0, 180);
    run_phase(1'b1, 5'd14, 5'd12, 1'b0, 1'b1, 66, 0, 0, 1'b0, 180);
    run_phase(1'b1, 5'd19, 5'd17, 1'b1, 1'b0, 0, 66, 0, 1'b0, 180);
    run_phase(1'b1, 5'd0, 5'd31, 1'b0, 1'b1, 23, 23, 0, 1'b0, 180);
    run_phase(1'b1, 5'd31, 5'd0, 1'b1, 1'b1, 0, 0, 300, 1'b0, 180);
    run_phase(1'b1, 5'd16, 5'd15, 1'b0, 1'b0, 23, 23, 0, 1'b1, 180);
    run_phase(1'b1, 5'd17, 5'd14, 1'b1, 1'b0, 0, 66, 0, 1'b0, 180);

    drain_results();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sbsm_pkg.sv
sv/sbsm_cfg.sv
sv/sbsm_bank_regs.sv
sv/sbsm_xlate.sv
sv/serial_bank_switch_mapper_unit.sv
test/sbsm_bank_map_checker.sv
test/tb_top.sv
